// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// CCE_ASSERT expects signals named clk and rst, CCE_ASSERT_ALWAYS only clk, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/cce_pkg.sv
package cce_pkg;

  // Field widths of the register file and of the result stream.
  localparam int ITEM_W    = 16;
  localparam int CHUNK_W   = 16;
  localparam int TUPLE_W   = 4;
  localparam int POS_W     = 3;
  localparam int CHOICE_W  = 16;
  localparam int REG_IDX_W = 2;

  // Multiplier operands: a chunk index plus a tuple offset, times a chunk size.
  localparam int MUL_A_W = CHOICE_W + 1;
  localparam int PROD_W  = MUL_A_W + CHUNK_W;

  localparam int DEFAULT_MAX_TUPLE = 8;

  // Register reset values.
  localparam logic [ITEM_W-1:0]  RESET_ITEM_COUNT = 16'd0;
  localparam logic [CHUNK_W-1:0] RESET_CHUNK_SIZE = 16'd10;
  localparam logic [TUPLE_W-1:0] RESET_TUPLE_SIZE = 4'd5;

  // Register indexes of the write port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ITEM_COUNT = 2'd0,
    REG_CHUNK_SIZE = 2'd1,
    REG_TUPLE_SIZE = 2'd2
  } reg_idx_t;

  // Effective settings handed to the enumeration engine.
  typedef struct packed {
    logic [ITEM_W-1:0]  item_count;
    logic [CHUNK_W-1:0] chunk;
    logic [TUPLE_W-1:0] k_last;
  } cce_cfg_t;

endpackage

// File: hw/rtl/cce_if.sv
// Request channel: one transfer asks for the next tuple or restarts.
interface cce_req_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one transfer per chunk of a tuple, or one exhausted mark.
interface cce_res_if import cce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] first_item;
  logic [ITEM_W-1:0] last_item;
  logic              last_of_tuple;
  logic              exhausted;

  modport source (output valid, output position, output first_item, output last_item,
                  output last_of_tuple, output exhausted, input ready);
  modport sink (input valid, input position, input first_item, input last_item,
                input last_of_tuple, input exhausted, output ready);
endinterface

// File: hw/rtl/cce_choice_mem.sv
module cce_choice_mem import cce_pkg::*; #(
  parameter int DEPTH = DEFAULT_MAX_TUPLE,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [CHOICE_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [CHOICE_W-1:0] rdata
);

  logic [CHOICE_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/cce_mul.sv
module cce_mul import cce_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [CHUNK_W-1:0] b,
  output logic [PROD_W-1:0]  prod
);

  // Registered product; it holds while the enable is low.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// File: hw/rtl/cce_engine.sv
module cce_engine import cce_pkg::*; #(
  parameter int MAX_TUPLE = DEFAULT_MAX_TUPLE
) (
  input  logic      clk,
  input  logic      rst,
  input  cce_cfg_t  cfg,
  input  logic      cfg_clr,
  cce_req_if.sink   req,
  cce_res_if.source res
);

  localparam int AW = (MAX_TUPLE > 1) ? $clog2(MAX_TUPLE) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_MUL,
    S_CHK,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_MUL,
    S_SCAN_CMP,
    S_REFILL,
    S_EMIT_RD,
    S_EMIT_MUL,
    S_EMIT_FMT,
    S_EXH
  } state_t;

  state_t              state;
  logic                started;
  logic                finished;
  logic [AW-1:0]       idx;
  logic [CHOICE_W-1:0] val;

  logic                out_valid;
  logic [POS_W-1:0]    out_position;
  logic [ITEM_W-1:0]   out_first;
  logic [ITEM_W-1:0]   out_last;
  logic                out_lot;
  logic                out_exh;
  logic                out_load;

  logic                mem_we;
  logic [CHOICE_W-1:0] mem_wdata;
  logic [CHOICE_W-1:0] rdata;
  logic                mul_en;
  logic [MUL_A_W-1:0]  mul_a;
  logic [PROD_W-1:0]   prod;

  logic [AW-1:0]       klast;
  logic [TUPLE_W:0]    k_val;
  logic                out_free;
  logic                prod_lt_n;
  logic [PROD_W:0]     end_sum;
  logic [PROD_W:0]     end_clip;
  logic [ITEM_W-1:0]   last_calc;

  cce_choice_mem #(
    .DEPTH (MAX_TUPLE),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  cce_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (cfg.chunk),
    .prod (prod)
  );

  // Tuple length, compare against the item count and chunk end clipping.
  assign klast     = cfg.k_last[AW-1:0];
  assign k_val     = {1'b0, cfg.k_last} + 1'b1;
  assign out_free  = !out_valid || res.ready;
  assign prod_lt_n = prod < PROD_W'(cfg.item_count);
  assign end_sum   = {1'b0, prod} + (PROD_W + 1)'(cfg.chunk);
  assign end_clip  = (end_sum > (PROD_W + 1)'(cfg.item_count)) ?
                     (PROD_W + 1)'(cfg.item_count) : end_sum;
  assign last_calc = ITEM_W'(end_clip - 1'b1);

  // The output register takes a new result when it is free in an emitting state.
  assign out_load  = ((state == S_EMIT_FMT) || (state == S_EXH)) && out_free;

  // Memory write and multiplier operand selection per step.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mul_en    = 1'b0;
    mul_a     = '0;
    case (state)
      S_CHK_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(cfg.k_last);
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = CHOICE_W'(idx);
      end
      S_SCAN_MUL: begin
        // Position may grow when choice + k - position stays below the chunk count.
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rdata) + MUL_A_W'(k_val) - MUL_A_W'(idx);
      end
      S_SCAN_CMP: begin
        mem_we    = prod_lt_n;
        mem_wdata = val + 1'b1;
      end
      S_REFILL: begin
        mem_we    = 1'b1;
        mem_wdata = val + 1'b1;
      end
      S_EMIT_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rdata);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register. Each write lands before the read of the
  // same entry is issued, so no forwarding is needed. The user must make
  // register writes only while the engine is idle; the engine does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.restart || cfg_clr) begin
              started  <= 1'b0;
              finished <= 1'b0;
              state    <= S_CHK_MUL;
            end else if (finished) begin
              state <= S_EXH;
            end else if (!started) begin
              state <= S_CHK_MUL;
            end else begin
              idx   <= klast;
              state <= S_SCAN_RD;
            end
          end else if (cfg_clr) begin
            started  <= 1'b0;
            finished <= 1'b0;
          end
        end
        S_CHK_MUL: begin
          state <= S_CHK;
        end
        S_CHK: begin
          // A tuple exists when (k - 1) * chunk lies below the item count.
          if (prod_lt_n) begin
            idx   <= '0;
            state <= S_FILL;
          end else begin
            state <= S_EXH;
          end
        end
        S_FILL: begin
          if (idx == klast) begin
            started <= 1'b1;
            idx     <= '0;
            state   <= S_EMIT_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_MUL;
        end
        S_SCAN_MUL: begin
          val   <= rdata;
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (prod_lt_n) begin
            val <= val + 1'b1;
            if (idx == klast) begin
              idx   <= '0;
              state <= S_EMIT_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_REFILL;
            end
          end else if (idx == '0) begin
            state <= S_EXH;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_REFILL: begin
          val <= val + 1'b1;
          if (idx == klast) begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_MUL;
        end
        S_EMIT_MUL: begin
          state <= S_EMIT_FMT;
        end
        S_EMIT_FMT: begin
          if (out_free) begin
            out_position <= POS_W'(idx);
            out_first    <= ITEM_W'(prod);
            out_last     <= last_calc;
            out_lot      <= (idx == klast);
            out_exh      <= 1'b0;
            if (idx == klast) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        S_EXH: begin
          if (out_free) begin
            out_position <= '0;
            out_first    <= '0;
            out_last     <= '0;
            out_lot      <= 1'b0;
            out_exh      <= 1'b1;
            finished     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign res.valid         = out_valid;
  assign res.position      = out_position;
  assign res.first_item    = out_first;
  assign res.last_item     = out_last;
  assign res.last_of_tuple = out_lot;
  assign res.exhausted     = out_exh;

endmodule

// File: hw/rtl/chunk_combination_enumerator.sv
// Chunk combination enumerator. Items 0..item_count-1 are cut into chunks of
// chunk_size items (the last one ends at item_count), and each request
// transfer returns the next lexicographic choice of tuple_size distinct
// chunks as tuple_size result transfers, one per chunk with its first and
// last item, the final one marked last_of_tuple. With no tuple left, one
// result with only exhausted set is returned, until a restart request or a
// register write. The chosen chunk indices live in a small synchronous RAM
// and one shared 17x16 multiplier maps indices to item positions. Steps per
// request with k chunks per tuple: the first tuple multiplies and checks that
// a tuple exists, fills k positions, then emits; a later tuple reads,
// multiplies and compares each position scanned from the right, rewrites
// each trailing position, then emits; emitting reads, multiplies and formats
// each chunk in turn. An exhausted answer comes straight once the walk is
// over, after the check when no tuple exists, and after the full scan when
// no position is left to grow. Stalls on the result side hold the format and
// exhausted steps. The RAM port and the multiplier are used once per step. A
// new request is taken while the last result of the previous one still waits at the output.
module chunk_combination_enumerator import cce_pkg::*; #(
  parameter int MAX_TUPLE = DEFAULT_MAX_TUPLE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CHUNK_W-1:0]   wr_data,
  cce_req_if.sink              req,
  cce_res_if.source            res
);

  logic [ITEM_W-1:0]  item_count;
  logic [CHUNK_W-1:0] chunk_size;
  logic [TUPLE_W-1:0] tuple_size;
  logic               cfg_clr;
  cce_cfg_t           cfg;

  // Register file; a write to a listed register restarts the enumeration.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= RESET_ITEM_COUNT;
      chunk_size <= RESET_CHUNK_SIZE;
      tuple_size <= RESET_TUPLE_SIZE;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_ITEM_COUNT: item_count <= ITEM_W'(wr_data);
        REG_CHUNK_SIZE: chunk_size <= wr_data;
        REG_TUPLE_SIZE: tuple_size <= TUPLE_W'(wr_data);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_clr = 1'b0;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_ITEM_COUNT, REG_CHUNK_SIZE, REG_TUPLE_SIZE: cfg_clr = 1'b1;
        default: cfg_clr = 1'b0;
      endcase
    end
  end

  // Effective settings: zero chunk and tuple sizes count as one, and the
  // tuple size is capped at the RAM depth.
  always_comb begin
    cfg.item_count = item_count;
    cfg.chunk      = (chunk_size == '0) ? CHUNK_W'(1) : chunk_size;
    if (tuple_size == '0) begin
      cfg.k_last = '0;
    end else if ({1'b0, tuple_size} > (TUPLE_W + 1)'(MAX_TUPLE)) begin
      cfg.k_last = TUPLE_W'(MAX_TUPLE - 1);
    end else begin
      cfg.k_last = tuple_size - 1'b1;
    end
  end

  cce_engine #(
    .MAX_TUPLE (MAX_TUPLE)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_clr (cfg_clr),
    .req     (req),
    .res     (res)
  );

endmodule

// File: hw/rtl/cce_checker.sv
`include "assert_macros.svh"

module cce_checker import cce_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  position,
  input logic [ITEM_W-1:0] first_item,
  input logic [ITEM_W-1:0] last_item,
  input logic              last_of_tuple,
  input logic              exhausted
);

  // An exhausted result carries nothing else.
  `CCE_ASSERT(a_exh_zero, out_valid && exhausted |-> position == '0 && first_item == '0 && last_item == '0 && !last_of_tuple, "exhausted result with nonzero fields")

  // A chunk never ends before it starts.
  `CCE_ASSERT(a_chunk_order, out_valid && !exhausted |-> last_item >= first_item, "chunk last item below first item")

  // A request transfer starts work, so ready is low in the cycle after it.
  `CCE_ASSERT(a_req_busy, in_valid && in_ready |=> !in_ready, "request taken in back-to-back cycles")

  // A stalled result stays put.
  `CCE_ASSERT(a_res_hold, out_valid && !out_ready |=> out_valid && $stable(first_item) && $stable(position), "stalled result changed")

  // Reset empties the output register.
  `CCE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind chunk_combination_enumerator cce_checker u_cce_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .position      (res.position),
  .first_item    (res.first_item),
  .last_item     (res.last_item),
  .last_of_tuple (res.last_of_tuple),
  .exhausted     (res.exhausted)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cce_pkg::*;

  localparam int MAX_TUPLE = DEFAULT_MAX_TUPLE;
  localparam int STALL_LIMIT = 4000;
  localparam int SHOWN_MISMATCHES = 10;
  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] first_item;
    logic [ITEM_W-1:0] last_item;
    logic              last_of_tuple;
    logic              exhausted;
  } chunk_result_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [CHUNK_W-1:0]   wr_data;

  cce_req_if req_ch ();
  cce_res_if res_ch ();

  chunk_combination_enumerator #(.MAX_TUPLE(MAX_TUPLE)) uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  // Shadow copy of the register file and of the enumeration state.
  logic [ITEM_W-1:0]   model_items;
  logic [CHUNK_W-1:0]  model_chunk;
  logic [TUPLE_W-1:0]  model_tuple;
  logic [CHOICE_W-1:0] chosen_chunk [MAX_TUPLE];
  bit                  walk_started;
  bit                  walk_done;

  chunk_result_t pending_chunks [$];
  int unsigned   mismatch_count;
  int unsigned   idle_cycles;
  bit            steady;

  chunk_result_t got_chunk;
  chunk_result_t want_chunk;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, sometimes long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Works out the chunks that one accepted request must produce.
  function automatic void advance_enumeration(input bit restart_flag);
    int unsigned k;
    int unsigned cs;
    int unsigned n;
    int unsigned total;
    int unsigned pos;
    int unsigned first;
    int unsigned stop;
    bit          gives_none;
    chunk_result_t item;

    cs = (model_chunk == '0) ? 1 : model_chunk;
    k = (model_tuple == '0) ? 1 : model_tuple;
    if (k > MAX_TUPLE) k = MAX_TUPLE;
    n = model_items;
    total = (n + cs - 1) / cs;
    gives_none = 1'b0;

    if (restart_flag) begin
      walk_started = 1'b0;
      walk_done = 1'b0;
    end

    if (walk_done) begin
      gives_none = 1'b1;
    end else if (!walk_started) begin
      if (k > total) begin
        gives_none = 1'b1;
      end else begin
        for (int i = 0; i < k; i++) chosen_chunk[i] = i;
        walk_started = 1'b1;
      end
    end else begin
      // Find the rightmost position that can still move up.
      pos = k;
      while (pos > 0) begin
        if (chosen_chunk[pos-1] < total - k + pos - 1) break;
        pos--;
      end
      if (pos == 0) begin
        gives_none = 1'b1;
      end else begin
        pos--;
        chosen_chunk[pos] = chosen_chunk[pos] + 1'b1;
        for (int i = pos + 1; i < k; i++) chosen_chunk[i] = chosen_chunk[i-1] + 1'b1;
      end
    end

    if (gives_none) begin
      walk_done = 1'b1;
      item = '0;
      item.exhausted = 1'b1;
      pending_chunks = {pending_chunks, item};
    end else begin
      for (int p = 0; p < k; p++) begin
        first = chosen_chunk[p] * cs;
        stop = first + cs;
        if (stop > n) stop = n;
        item.position = p[POS_W-1:0];
        item.first_item = first[ITEM_W-1:0];
        item.last_item = stop - 1;
        item.last_of_tuple = (p == k - 1);
        item.exhausted = 1'b0;
        pending_chunks = {pending_chunks, item};
      end
    end
  endfunction

  // Sends one request after a random gap and waits for its transfer.
  task automatic send_request(input bit restart_flag);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.restart <= restart_flag;
    do @(posedge clk); while (!req_ch.ready);
    advance_enumeration(restart_flag);
  endtask

  // Lets every expected chunk arrive, then a short pause for the engine.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_chunks.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes one register; any known register also restarts the walk.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CHUNK_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_ITEM_COUNT: model_items = data;
      REG_CHUNK_SIZE: model_chunk = data;
      REG_TUPLE_SIZE: model_tuple = data[TUPLE_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      walk_started = 1'b0;
      walk_done = 1'b0;
    end
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [ITEM_W-1:0] n, input logic [CHUNK_W-1:0] cs,
                              input logic [CHUNK_W-1:0] k);
    write_reg(REG_ITEM_COUNT, n);
    write_reg(REG_CHUNK_SIZE, cs);
    write_reg(REG_TUPLE_SIZE, k);
  endtask

  // Out of reset there are no items, so only the exhausted mark comes back.
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b0);
    settle();
  endtask

  // Three chunks with a short last one, walked to the end and restarted.
  task automatic test_short_last_chunk();
    set_geometry(16'd25, 16'd10, 16'd2);
    repeat (5) send_request(1'b0);
    send_request(1'b1);
    settle();
  endtask

  // Chunk size zero and tuple size zero act as one; an oversize tuple as the maximum.
  task automatic test_size_clamps();
    set_geometry(16'd8, 16'd0, 16'd0);
    send_request(1'b0);
    send_request(1'b0);
    settle();
    write_reg(REG_TUPLE_SIZE, 16'd15);
    send_request(1'b0);
    send_request(1'b0);
    settle();
  endtask

  // Fewer chunks than the tuple needs: no tuple exists at all.
  task automatic test_too_few_chunks();
    set_geometry(16'd30, 16'd10, 16'd4);
    send_request(1'b0);
    settle();
  endtask

  // A write to the unused index keeps the walk; a real write restarts it.
  task automatic test_write_restarts();
    set_geometry(16'd40, 16'd10, 16'd2);
    send_request(1'b0);
    send_request(1'b0);
    settle();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_request(1'b0);
    settle();
    write_reg(REG_CHUNK_SIZE, 16'd10);
    send_request(1'b0);
    settle();
  endtask

  // Item indexes near the top of the range, with junk in the upper tuple bits.
  task automatic test_wide_items();
    set_geometry(16'hFFFF, 16'h5555, 16'h0002);
    repeat (4) send_request(1'b0);
    settle();
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFF1);
    send_request(1'b0);
    send_request(1'b0);
    settle();
  endtask

  // Random geometries, mostly small, each walked with occasional restarts.
  task automatic test_random_walks();
    int unsigned requests;
    logic [ITEM_W-1:0]  n;
    logic [CHUNK_W-1:0] cs;
    logic [CHUNK_W-1:0] k;
    for (int phase = 0; phase < 7; phase++) begin
      steady = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 60));
      cs = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20));
      k = {12'($urandom()), 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                        : $urandom_range(1, 5))};
      set_geometry(n, cs, k);
      requests = $urandom_range(14, 24);
      for (int r = 0; r < requests; r++) begin
        send_request($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 19) == 0) begin
          settle();
          write_reg(REG_UNUSED, 16'($urandom()));
        end
      end
      settle();
    end
    steady = 1'b0;
  endtask

  // Result sink: random stalls, with stretches of full throughput.
  initial begin
    int unsigned hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  // Compare each result transfer with the oldest expected chunk.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_chunk.position = res_ch.position;
      got_chunk.first_item = res_ch.first_item;
      got_chunk.last_item = res_ch.last_item;
      got_chunk.last_of_tuple = res_ch.last_of_tuple;
      got_chunk.exhausted = res_ch.exhausted;
      if (pending_chunks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("Unexpected result: pos %0d first %0d last %0d lot %0d exh %0d",
                   got_chunk.position, got_chunk.first_item, got_chunk.last_item,
                   got_chunk.last_of_tuple, got_chunk.exhausted);
      end else begin
        want_chunk = pending_chunks.pop_front();
        if (got_chunk !== want_chunk) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("Mismatch: expected pos %0d first %0d last %0d lot %0d exh %0d, got pos %0d first %0d last %0d lot %0d exh %0d",
                     want_chunk.position, want_chunk.first_item, want_chunk.last_item,
                     want_chunk.last_of_tuple, want_chunk.exhausted,
                     got_chunk.position, got_chunk.first_item, got_chunk.last_item,
                     got_chunk.last_of_tuple, got_chunk.exhausted);
        end
      end
    end
  end

  // Watchdog: too long without any transfer or register write.
  always @(posedge clk) begin
    if (rst || wr_en || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_ITEM_COUNT;
    wr_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.restart <= 1'b0;
    idle_cycles <= 0;
    mismatch_count = 0;
    steady = 1'b0;
    model_items = RESET_ITEM_COUNT;
    model_chunk = RESET_CHUNK_SIZE;
    model_tuple = RESET_TUPLE_SIZE;
    for (int i = 0; i < MAX_TUPLE; i++) chosen_chunk[i] = '0;
    walk_started = 1'b0;
    walk_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_short_last_chunk();
    test_size_clamps();
    test_too_few_chunks();
    test_write_restarts();
    test_wide_items();
    test_random_walks();

    // Drain, then give a late extra result time to show up.
    settle();
    repeat (60) @(posedge clk);
    if (pending_chunks.size() > 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", pending_chunks.size());
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
